// ===== hw/rtl/bsqrt_pkg.sv =====
// shared types and constants for the bisection square root core
`timescale 1ns / 1ps

package bsqrt_pkg;

  localparam int VAL_W  = 32;
  localparam int ITER_W = 7;
  localparam int SQ_W   = 2 * VAL_W;
  localparam int OUT_W  = 40;

  localparam logic [VAL_W-1:0] TOL_RESET = 32'd6554;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic tol_met;
    logic cap;
  } status_t;

endpackage

// ===== hw/rtl/bsqrt_ctrl.sv =====
// controller state machine: request handshake, search sequencing, result register valid
`timescale 1ns / 1ps

module bsqrt_ctrl
  import bsqrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_finish;

  assign can_finish = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        state_nxt = status.special ? ST_FINISH : ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = (status.tol_met || status.cap) ? ST_FINISH : ST_SQUARE;
      end
      ST_FINISH: begin
        if (can_finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
      end
      ST_EVAL: begin
        cmd.step = !(status.tol_met || status.cap);
      end
      ST_FINISH: begin
        cmd.finish = can_finish;
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.finish || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

endmodule

// ===== hw/rtl/bsqrt_dp.sv =====
// datapath: bounds, midpoint, squarer, tolerance window and result register
`timescale 1ns / 1ps

module bsqrt_dp
  import bsqrt_pkg::*;
#(
  parameter int MAX_ITER  = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [VAL_W-1:0] in_value,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_tol,
  output logic [VAL_W-1:0] root,
  output logic [ITER_W-1:0] iterations,
  output logic             converged
);

  localparam logic [VAL_W-1:0]  ONE        = VAL_W'(1) << FRAC_BITS;
  localparam logic [ITER_W-1:0] MAX_ITER_C = ITER_W'(MAX_ITER);

  logic [VAL_W-1:0]  tol_r;
  logic [SQ_W-1:0]   tgt_r, up_r, dn_r, sq_r;
  logic [VAL_W-1:0]  lo_r, hi_r, x_r;
  logic [ITER_W-1:0] steps_r;
  logic              special_r;
  logic [VAL_W-1:0]  root_r;
  logic [ITER_W-1:0] iter_r;
  logic              conv_r;

  logic [SQ_W-1:0]   tol_wide, up_nxt, dn_nxt, sq_nxt;
  logic              lt;
  logic [VAL_W-1:0]  lo_nxt, hi_nxt, hi_init;
  logic [VAL_W:0]    mid_sum;
  logic              special_in;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_tol;
    end
  end

  assign special_in = (in_value == '0) || (in_value == ONE);
  assign hi_init    = (in_value >= ONE) ? in_value : ONE;

  // acceptance window around the target in the wide format
  assign tol_wide = SQ_W'(tol_r) << FRAC_BITS;
  assign up_nxt   = tgt_r + tol_wide;
  assign dn_nxt   = (tgt_r > tol_wide) ? (tgt_r - tol_wide) : '0;
  assign sq_nxt   = SQ_W'(x_r) * SQ_W'(x_r);

  assign lt      = sq_r < tgt_r;
  assign lo_nxt  = lt ? x_r : lo_r;
  assign hi_nxt  = lt ? hi_r : x_r;
  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r     <= SQ_W'(in_value) << FRAC_BITS;
      lo_r      <= '0;
      hi_r      <= hi_init;
      x_r       <= special_in ? in_value : (hi_init >> 1);
      special_r <= special_in;
    end else if (cmd.step) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      x_r  <= mid_sum[VAL_W:1];
    end
    if (cmd.square) begin
      sq_r <= sq_nxt;
      up_r <= up_nxt;
      dn_r <= dn_nxt;
    end
    if (cmd.finish) begin
      root_r <= x_r;
      iter_r <= steps_r;
      conv_r <= special_r || status.tol_met;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= '0;
    end else if (cmd.load) begin
      steps_r <= '0;
    end else if (cmd.step) begin
      steps_r <= steps_r + ITER_W'(1);
    end
  end

  assign status.special = special_r;
  assign status.tol_met = (sq_r <= up_r) && (sq_r >= dn_r);
  assign status.cap     = steps_r >= MAX_ITER_C;

  assign root       = root_r;
  assign iterations = iter_r;
  assign converged  = conv_r;

endmodule

// ===== hw/rtl/bisection_square_root_core.sv =====
// top level of the bisection square root core
// a value is accepted only in idle; the core then alternates the square and evaluate states until
// the tolerance is met or the step cap is reached, and registers the result in the finish state
// a zero or one input goes from square straight to finish; at most MAX_ITER steps per value
// each step is one pass of the single squarer (square state) and one compare/update (evaluate state)
// synchronous active-low reset clears control and loads the tolerance reset value
`timescale 1ns / 1ps

module bisection_square_root_core
  import bsqrt_pkg::*;
#(
  parameter int MAX_ITER  = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [VAL_W-1:0] in_tdata,   // value[31:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // root[31:0], iterations[38:32], converged[39]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VAL_W-1:0] cfg_data    // tolerance[31:0]
);

  cmd_t              cmd;
  status_t           status;
  logic [VAL_W-1:0]  root;
  logic [ITER_W-1:0] iterations;
  logic              converged;

  assign cfg_ready = 1'b1;

  bsqrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bsqrt_dp #(
    .MAX_ITER  (MAX_ITER),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_value   (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_tol    (cfg_data),
    .root       (root),
    .iterations (iterations),
    .converged  (converged)
  );

  assign out_tdata = {converged, iterations, root};

endmodule

// ===== hw/rtl/bsqrt_chk.sv =====
// port-level checker for the bisection square root core, with its bind
`timescale 1ns / 1ps

module bsqrt_chk
  import bsqrt_pkg::*;
#(
  parameter int MAX_ITER = 48
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam logic [ITER_W-1:0] MAX_ITER_C = ITER_W'(MAX_ITER);

  // one request in flight: input side closes after a request
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a request is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_iter_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[38:32] <= MAX_ITER_C)
    else $error("iteration count above cap");

  a_cap_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[39] |-> out_tdata[38:32] == MAX_ITER_C)
    else $error("not converged before reaching the cap");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the result side");

endmodule

bind bisection_square_root_core bsqrt_chk #(.MAX_ITER(MAX_ITER)) u_bsqrt_chk (.*);

// ===== verif/bisection_square_root_core_tb.sv =====
// testbench for the bisection square root core: directed table, random values, scoreboard
`timescale 1ns / 1ps

module bisection_square_root_core_tb;
  import bsqrt_pkg::*;

  localparam int MAX_ITER    = 48;
  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEGMENTS    = 8;
  localparam int SEG_ITEMS   = 210;

  typedef struct packed {
    logic [VAL_W-1:0]  root;
    logic [ITER_W-1:0] iterations;
    logic              converged;
  } sqrt_result_t;

  typedef struct packed {
    logic [VAL_W-1:0] tol;
    logic [VAL_W-1:0] value;
    logic             typed;
    sqrt_result_t     want;
  } sqrt_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [VAL_W-1:0] cfg_data;

  sqrt_result_t     pending_roots[$];
  sqrt_row_t        directed_rows[$];
  logic [VAL_W-1:0] tolerance_q;
  int               sender_idle_pct;
  int               recv_stall_pct;
  int               mismatch_count;
  int               cycle_count;

  bisection_square_root_core #(
    .MAX_ITER (MAX_ITER),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sqrt_result_t bisect_sqrt(input logic [VAL_W-1:0] value,
                                               input logic [VAL_W-1:0] tol);
    logic [63:0]  one_q;
    logic [63:0]  target;
    logic [63:0]  tol_q;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  x;
    logic [63:0]  sq;
    logic [63:0]  diff;
    int           steps;
    bit           done;
    sqrt_result_t r;
    one_q  = 64'd1 << FRAC_BITS;
    target = {32'd0, value} << FRAC_BITS;
    tol_q  = {32'd0, tol} << FRAC_BITS;
    r.root       = '0;
    r.iterations = '0;
    r.converged  = 1'b1;
    if (value == 0) begin
      return r;
    end
    if ({32'd0, value} == one_q) begin
      r.root = one_q[VAL_W-1:0];
      return r;
    end
    lo    = '0;
    hi    = ({32'd0, value} >= one_q) ? {32'd0, value} : one_q;
    x     = (lo + hi) >> 1;
    steps = 0;
    done  = 1'b0;
    while (!done) begin
      sq   = x * x;
      diff = (sq >= target) ? (sq - target) : (target - sq);
      if (diff <= tol_q) begin
        done = 1'b1;
      end else if (steps >= MAX_ITER) begin
        r.converged = 1'b0;
        done        = 1'b1;
      end else begin
        if (sq < target) begin
          lo = x;
        end else begin
          hi = x;
        end
        x     = (lo + hi) >> 1;
        steps = steps + 1;
      end
    end
    r.root       = x[VAL_W-1:0];
    r.iterations = steps[ITER_W-1:0];
    return r;
  endfunction

  // result side: random backpressure and scoreboard
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sqrt_result_t got;
    sqrt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.root       = out_tdata[31:0];
      got.iterations = out_tdata[38:32];
      got.converged  = out_tdata[39];
      if (pending_roots.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
          $display("unexpected result: root=%h iterations=%0d converged=%0b",
                   got.root, got.iterations, got.converged);
        end
      end else begin
        want = pending_roots.pop_front();
        if (got != want) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected root=%h iterations=%0d converged=%0b,",
                     want.root, want.iterations, want.converged,
                     " got root=%h iterations=%0d converged=%0b",
                     got.root, got.iterations, got.converged);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // the timed tasks (wait_drained, write_tolerance, send_value) are entered and left at a falling edge
  task automatic wait_drained();
    while (pending_roots.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_tolerance(input logic [VAL_W-1:0] t);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    do @(posedge clk); while (!cfg_ready);
    tolerance_q = t;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_value(input logic [VAL_W-1:0] v, input logic typed,
                            input sqrt_result_t want);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    pending_roots.push_back(typed ? want : bisect_sqrt(v, tolerance_q));
    @(negedge clk);
  endtask

  task automatic add_row(input logic [VAL_W-1:0] tol, input logic [VAL_W-1:0] value,
                         input logic typed, input logic [VAL_W-1:0] root,
                         input logic [ITER_W-1:0] iterations, input logic converged);
    sqrt_row_t row;
    row.tol             = tol;
    row.value           = value;
    row.typed           = typed;
    row.want.root       = root;
    row.want.iterations = iterations;
    row.want.converged  = converged;
    directed_rows.push_back(row);
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    int          kind;
    logic [63:0] r;
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5: begin
        return $urandom_range(0, 32'h0003FFFF);
      end
      6: begin
        r = 64'($urandom_range(0, 32'h00FFFFFF));
        r = (r * r) >> FRAC_BITS;
        return r[VAL_W-1:0];
      end
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h0;
          1: return 32'h00010000;
          2: return 32'hFFFFFFFF;
          default: return 32'h1;
        endcase
      end
      8: begin
        return 32'h00010000 + $urandom_range(0, 255) - 128;
      end
      9: begin
        return $urandom | 32'h80000000;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  initial begin
    sqrt_result_t     none;
    logic [VAL_W-1:0] tol;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    tolerance_q     = TOL_RESET;
    none            = '0;

    // zero, one, extremes and step cap cases
    add_row(TOL_RESET,    32'h00000000, 1'b1, 32'h00000000, 7'd0, 1'b1);
    add_row(TOL_RESET,    32'h00010000, 1'b1, 32'h00010000, 7'd0, 1'b1);
    add_row(TOL_RESET,    32'hFFFFFFFF, 1'b0, '0, '0, 1'b0);
    add_row(TOL_RESET,    32'h00000001, 1'b0, '0, '0, 1'b0);
    add_row(TOL_RESET,    32'h00040000, 1'b0, '0, '0, 1'b0);
    add_row(TOL_RESET,    32'h00020000, 1'b0, '0, '0, 1'b0);
    add_row(TOL_RESET,    32'h00008000, 1'b0, '0, '0, 1'b0);
    add_row(TOL_RESET,    32'h80000000, 1'b0, '0, '0, 1'b0);
    add_row(TOL_RESET,    32'h0000FFFF, 1'b0, '0, '0, 1'b0);
    add_row(TOL_RESET,    32'h00010001, 1'b0, '0, '0, 1'b0);
    add_row(32'h00000000, 32'h00020000, 1'b0, '0, '0, 1'b0);
    add_row(32'h00000000, 32'h00040000, 1'b1, 32'h00020000, 7'd0, 1'b1);
    add_row(32'h00000000, 32'hFFFFFFFF, 1'b0, '0, '0, 1'b0);
    add_row(32'h00000000, 32'h00000003, 1'b0, '0, '0, 1'b0);
    add_row(32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 7'd0, 1'b1);
    add_row(32'hFFFFFFFF, 32'h00000002, 1'b1, 32'h00008000, 7'd0, 1'b1);
    add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0, '0, 1'b0);
    add_row(32'hFFFFFFFF, 32'h00010000, 1'b1, 32'h00010000, 7'd0, 1'b1);
    add_row(32'h00000001, 32'h12345678, 1'b0, '0, '0, 1'b0);
    add_row(32'h00000001, 32'hA5A5A5A5, 1'b0, '0, '0, 1'b0);
    add_row(32'h00000001, 32'h5A5A5A5A, 1'b0, '0, '0, 1'b0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].tol != tolerance_q) begin
        in_tvalid <= 1'b0;
        write_tolerance(directed_rows[i].tol);
      end
      send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: tol = TOL_RESET;
        1: tol = 32'h00000000;
        2: tol = 32'hFFFFFFFF;
        4: tol = $urandom_range(0, 32'h0000FFFF);
        5: tol = 32'h00000001;
        7: tol = $urandom_range(0, 32'h000FFFFF);
        default: tol = $urandom;
      endcase
      in_tvalid <= 1'b0;
      write_tolerance(tol);
      case (seg % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 75;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 75;
        end
        default: begin
          sender_idle_pct = 34;
          recv_stall_pct  = 34;
        end
      endcase
      for (int k = 0; k < SEG_ITEMS; k++) begin
        send_value(random_value(), 1'b0, none);
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (2 * MAX_ITER + 8) @(negedge clk);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== bisection_square_root_core.f =====
hw/rtl/bsqrt_pkg.sv
hw/rtl/bsqrt_ctrl.sv
hw/rtl/bsqrt_dp.sv
hw/rtl/bisection_square_root_core.sv
hw/rtl/bsqrt_chk.sv
verif/bisection_square_root_core_tb.sv
